// File: rtl/sidu_pkg.sv
`timescale 1ns / 1ps

package sidu_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned HalfWidth = 16;
  // One restoring-division cell per quotient bit.
  localparam int unsigned NumCells  = DataWidth;

  typedef enum logic [1:0] {
    KindU16 = 2'd0,
    KindS16 = 2'd1,
    KindU32 = 2'd2,
    KindS32 = 2'd3
  } sidu_kind_e;

  // Work carried down the cell chain. The partial remainder sits in rem, and
  // num shifts left one bit per cell while the quotient bits fill it from the bottom.
  typedef struct packed {
    logic [DataWidth-1:0] rem;
    logic [DataWidth-1:0] num;
    logic [DataWidth-1:0] den;
    logic                 neg;
    logic                 zero;
    logic                 w16;
  } sidu_work_t;

endpackage

// File: rtl/sidu_prep.sv
`timescale 1ns / 1ps

module sidu_prep (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  sidu_pkg::sidu_kind_e                kind_i,
  input  logic [sidu_pkg::DataWidth-1:0]      dividend_i,
  input  logic [sidu_pkg::DataWidth-1:0]      divisor_i,
  output logic                                accept_o,
  output logic                                valid_o,
  output sidu_pkg::sidu_work_t                work_o,
  input  logic                                accept_i
);

  localparam int unsigned W = sidu_pkg::DataWidth;
  localparam int unsigned H = sidu_pkg::HalfWidth;

  logic                 w16, sgn, na, nb;
  logic [W-1:0]         a, b, mask, sign_bit, ma, mb;
  sidu_pkg::sidu_work_t work_d;
  logic                 valid_q;
  sidu_pkg::sidu_work_t work_q;

  always_comb begin
    w16 = 1'b0;
    sgn = 1'b0;
    unique case (kind_i)
      sidu_pkg::KindU16: begin w16 = 1'b1; sgn = 1'b0; end
      sidu_pkg::KindS16: begin w16 = 1'b1; sgn = 1'b1; end
      sidu_pkg::KindU32: begin w16 = 1'b0; sgn = 1'b0; end
      sidu_pkg::KindS32: begin w16 = 1'b0; sgn = 1'b1; end
      default:           begin w16 = 1'b0; sgn = 1'b0; end
    endcase

    mask     = w16 ? {{(W-H){1'b0}}, {H{1'b1}}} : {W{1'b1}};
    sign_bit = w16 ? {{(W-H){1'b0}}, 1'b1, {(H-1){1'b0}}} : {1'b1, {(W-1){1'b0}}};
    a        = dividend_i & mask;
    b        = divisor_i & mask;
    na       = sgn && ((a & sign_bit) != '0);
    nb       = sgn && ((b & sign_bit) != '0);
    ma       = na ? ((~a + 1'b1) & mask) : a;
    mb       = nb ? ((~b + 1'b1) & mask) : b;

    work_d.rem  = '0;
    work_d.num  = ma;
    work_d.den  = mb;
    work_d.neg  = na ^ nb;
    // Divide by zero, and the most negative dividend over minus one, both give zero.
    work_d.zero = (b == '0) || (sgn && (a == sign_bit) && (b == mask));
    work_d.w16  = w16;
  end

  assign accept_o = !valid_q || accept_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_o && valid_i) begin
      work_q <= work_d;
    end
  end

  assign valid_o = valid_q;
  assign work_o  = work_q;

endmodule

// File: rtl/sidu_cell.sv
`timescale 1ns / 1ps

module sidu_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  sidu_pkg::sidu_work_t work_i,
  output logic                 accept_o,
  output logic                 valid_o,
  output sidu_pkg::sidu_work_t work_o,
  input  logic                 accept_i
);

  localparam int unsigned W = sidu_pkg::DataWidth;

  logic [W:0]           shifted, den_ext, diff;
  logic                 ge;
  sidu_pkg::sidu_work_t work_d;
  logic                 valid_q;
  sidu_pkg::sidu_work_t work_q;

  // One restoring step: bring down the next dividend bit, subtract if it fits.
  always_comb begin
    shifted = {work_i.rem, work_i.num[W-1]};
    den_ext = {1'b0, work_i.den};
    diff    = shifted - den_ext;
    ge      = shifted >= den_ext;

    work_d     = work_i;
    work_d.rem = ge ? diff[W-1:0] : shifted[W-1:0];
    work_d.num = {work_i.num[W-2:0], ge};
  end

  assign accept_o = !valid_q || accept_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_o && valid_i) begin
      work_q <= work_d;
    end
  end

  assign valid_o = valid_q;
  assign work_o  = work_q;

endmodule

// File: rtl/sidu_fix.sv
`timescale 1ns / 1ps

module sidu_fix (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  sidu_pkg::sidu_work_t           work_i,
  output logic                           accept_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [sidu_pkg::DataWidth-1:0] quotient_o
);

  localparam int unsigned W = sidu_pkg::DataWidth;
  localparam int unsigned H = sidu_pkg::HalfWidth;

  logic [W-1:0] q_d, quotient_q;
  logic         out_valid_q;

  always_comb begin
    q_d = work_i.neg ? (~work_i.num + 1'b1) : work_i.num;
    if (work_i.w16) begin
      q_d = {{(W-H){1'b0}}, q_d[H-1:0]};
    end
    if (work_i.zero) begin
      q_d = '0;
    end
  end

  assign accept_o = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept_o) begin
      out_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_o && valid_i) begin
      quotient_q <= q_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign quotient_o  = quotient_q;

endmodule

// File: rtl/safe_integer_divider_unit.sv
`timescale 1ns / 1ps

// Pipelined integer divider for unsigned and signed 16-bit and 32-bit operands. It takes
// one beat per clock cycle while in_stall_o is low. Each beat passes through the operand
// stage, which forms the operand magnitudes, then each of the 32 restoring-division
// cells, one per quotient bit, and then the output register, which applies the sign.
// That chain of 32 cells sets the latency. Signed quotients truncate toward zero. A
// zero divisor, or the most negative dividend divided by minus one, gives a quotient
// of zero. 16-bit quotients are zero-extended. Each stage holds its beat while the
// stage after it is full and stalled, so empty stages close up and new beats are still
// taken while a result waits on the output. in_stall_o rises only when every stage is
// full.
module safe_integer_divider_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     kind_i,
  input  logic [sidu_pkg::DataWidth-1:0] dividend_i,
  input  logic [sidu_pkg::DataWidth-1:0] divisor_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [sidu_pkg::DataWidth-1:0] quotient_o
);

  localparam int unsigned N = sidu_pkg::NumCells;

  // Index 0 is the operand stage. Index k is the output of cell k.
  logic                 stage_valid  [N+1];
  logic                 stage_accept [N+1];
  sidu_pkg::sidu_work_t stage_work   [N+1];
  logic                 prep_accept;

  sidu_prep u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (in_valid_i),
    .kind_i     (sidu_pkg::sidu_kind_e'(kind_i)),
    .dividend_i (dividend_i),
    .divisor_i  (divisor_i),
    .accept_o   (prep_accept),
    .valid_o    (stage_valid[0]),
    .work_o     (stage_work[0]),
    .accept_i   (stage_accept[0])
  );

  // The cells pass the partial remainder down the chain, one quotient bit per cell.
  for (genvar g = 0; g < N; g++) begin : g_cell
    sidu_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .valid_i  (stage_valid[g]),
      .work_i   (stage_work[g]),
      .accept_o (stage_accept[g]),
      .valid_o  (stage_valid[g+1]),
      .work_o   (stage_work[g+1]),
      .accept_i (stage_accept[g+1])
    );
  end

  sidu_fix u_fix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (stage_valid[N]),
    .work_i      (stage_work[N]),
    .accept_o    (stage_accept[N]),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .quotient_o  (quotient_o)
  );

  assign in_stall_o = !prep_accept;

  // An empty output register lets every stage advance, so the input cannot be stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while the output register is empty");

  // The input is stalled only when the operand stage, the last cell and the output register are all full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (stage_valid[0] && stage_valid[N] && out_valid_o))
    else $error("input stalled while the pipeline has a bubble");

  // A new result appears only when the last cell held a beat in the cycle before.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(stage_valid[N]))
    else $error("result appeared without a beat in the last cell");

endmodule
